// ===== hdl/omp_pkg.sv =====
// ============================================================================
// omp_pkg - shared types and constants of the OSC message parser
// Phase codes, result kinds, character constants and the queue entry layout.
// ============================================================================
package omp_pkg;

    // Characters that the parser looks for
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Shortest packet that can be accepted, in bytes, minus one
    localparam logic [15:0] MIN_LAST_POS = 16'd7;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [15:0] POS_WRAP     = 16'hFFFC;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [3:0] {
        PH_ADDR_START = 4'd0,
        PH_ADDR       = 4'd1,
        PH_ADDR_PAD   = 4'd2,
        PH_TAG_COMMA  = 4'd3,
        PH_TAGS       = 4'd4,
        PH_ARG_PAD    = 4'd5,
        PH_ARG        = 4'd6,
        PH_DONE       = 4'd7,
        PH_FAIL       = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        KIND_ADDR     = 4'd0,
        KIND_TAG      = 4'd1,
        KIND_INT      = 4'd2,
        KIND_FLOAT    = 4'd3,
        KIND_TIMETAG  = 4'd4,
        KIND_STR_BYTE = 4'd5,
        KIND_STR_END  = 4'd6,
        KIND_ACCEPTED = 4'd7,
        KIND_REJECTED = 4'd8
    } t_kind;

    // What one input byte causes: an optional data result, then an optional verdict
    typedef struct packed {
        logic        has_data;
        t_kind       kind;
        logic [2:0]  slot;
        logic [63:0] value;
        logic        has_verdict;
        logic        ok;
    } t_entry;

endpackage

// ===== hdl/omp_front.sv =====
// ============================================================================
// omp_front - byte classifier and field assembler
// Walks the address, tag string and arguments, one byte per cycle while the queue
// has room, and hands the results of each byte to the queue as one entry.
// ============================================================================
module omp_front #(
    parameter int MAX_SLOTS = 8,
    parameter int TAG_DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_eop,
    input  logic            i_room,
    output logic            o_ready,
    output logic            o_push,
    output omp_pkg::t_entry o_entry
);
    import omp_pkg::*;

    localparam int TW = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
    localparam int CW = $clog2(TAG_DEPTH + 1);
    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TAG_DEPTH);
    localparam logic [SW-1:0] SLOTS_C = SW'(MAX_SLOTS);

    t_phase        r_phase,  n_phase;
    logic [15:0]   r_pos,    n_pos;
    logic [CW-1:0] r_count,  n_count;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [63:0]   r_word,   n_word;
    logic [2:0]    r_abc,    n_abc;
    logic [SW-1:0] r_iused,  n_iused;
    logic [SW-1:0] r_fused,  n_fused;
    logic [SW-1:0] r_tused,  n_tused;
    logic [SW-1:0] r_sused,  n_sused;
    logic          r_failed, n_failed;

    logic [7:0]    r_tag_mem [TAG_DEPTH];
    logic [7:0]    r_tag;
    logic          tag_we;

    logic          accept;
    logic          aligned;
    logic          do_next;
    logic          next_al;
    logic [63:0]   shifted;
    t_entry        ent;

    function automatic logic [2:0] slot3(input logic [SW-1:0] c);
        logic [SW+2:0] e;
        e = {3'b000, c};
        return e[2:0];
    endfunction

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign aligned = (r_pos[1:0] == 2'b11);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_word   = r_word;
        n_abc    = r_abc;
        n_iused  = r_iused;
        n_fused  = r_fused;
        n_tused  = r_tused;
        n_sused  = r_sused;
        n_failed = r_failed;
        tag_we   = 1'b0;
        do_next  = 1'b0;
        next_al  = aligned;
        shifted  = {r_word[55:0], i_byte};
        ent      = '0;
        ent.kind = KIND_ADDR;

        if (accept) begin
            case (r_phase)
                PH_ADDR_START: begin
                    if (i_byte == CH_SLASH) begin
                        ent.has_data = 1'b1;
                        ent.value    = {56'd0, i_byte};
                        n_phase      = PH_ADDR;
                    end else begin
                        n_failed = 1'b1;
                        n_phase  = PH_FAIL;
                    end
                end
                PH_ADDR: begin
                    if (i_byte == CH_NUL) begin
                        n_phase = aligned ? PH_TAG_COMMA : PH_ADDR_PAD;
                    end else begin
                        ent.has_data = 1'b1;
                        ent.value    = {56'd0, i_byte};
                    end
                end
                PH_ADDR_PAD: begin
                    if (aligned) n_phase = PH_TAG_COMMA;
                end
                PH_TAG_COMMA: begin
                    if (i_byte == CH_COMMA) begin
                        n_phase = PH_TAGS;
                    end else begin
                        n_failed = 1'b1;
                        n_phase  = PH_FAIL;
                    end
                end
                PH_TAGS: begin
                    if (i_byte == CH_NUL) begin
                        n_cursor = '0;
                        do_next  = 1'b1;
                    end else if (r_count >= DEPTH_C ||
                                 !(i_byte inside {CH_I, CH_F, CH_H, CH_T, CH_S})) begin
                        n_failed = 1'b1;
                        n_phase  = PH_FAIL;
                    end else begin
                        tag_we       = 1'b1;
                        n_count      = r_count + 1'b1;
                        ent.has_data = 1'b1;
                        ent.kind     = KIND_TAG;
                        ent.value    = {56'd0, i_byte};
                    end
                end
                PH_ARG_PAD: begin
                    if (aligned) begin
                        do_next = 1'b1;
                        next_al = 1'b1;
                    end
                end
                PH_ARG: begin
                    if (r_tag == CH_S) begin
                        if (i_byte == CH_NUL) begin
                            if (r_sused < SLOTS_C) begin
                                ent.has_data = 1'b1;
                                ent.kind     = KIND_STR_END;
                                ent.slot     = slot3(r_sused);
                                n_sused      = r_sused + 1'b1;
                            end
                            n_cursor = r_cursor + 1'b1;
                            do_next  = 1'b1;
                        end else if (r_sused < SLOTS_C) begin
                            ent.has_data = 1'b1;
                            ent.kind     = KIND_STR_BYTE;
                            ent.slot     = slot3(r_sused);
                            ent.value    = {56'd0, i_byte};
                        end
                    end else begin
                        n_word = shifted;
                        n_abc  = r_abc + 1'b1;
                        if ((r_tag == CH_I || r_tag == CH_F) && n_abc == 3'd4) begin
                            if (r_tag == CH_I) begin
                                if (r_iused < SLOTS_C) begin
                                    ent.has_data = 1'b1;
                                    ent.kind     = KIND_INT;
                                    ent.slot     = slot3(r_iused);
                                    ent.value    = {32'd0, shifted[31:0]};
                                    n_iused      = r_iused + 1'b1;
                                end
                            end else if (r_fused < SLOTS_C) begin
                                ent.has_data = 1'b1;
                                ent.kind     = KIND_FLOAT;
                                ent.slot     = slot3(r_fused);
                                ent.value    = {32'd0, shifted[31:0]};
                                n_fused      = r_fused + 1'b1;
                            end
                            n_cursor = r_cursor + 1'b1;
                            do_next  = 1'b1;
                        end else if ((r_tag == CH_H || r_tag == CH_T) && n_abc == 3'd0) begin
                            if (r_tag == CH_T && r_tused < SLOTS_C) begin
                                ent.has_data = 1'b1;
                                ent.kind     = KIND_TIMETAG;
                                ent.slot     = slot3(r_tused);
                                ent.value    = shifted;
                                n_tused      = r_tused + 1'b1;
                            end
                            n_cursor = r_cursor + 1'b1;
                            do_next  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            // field finished: clear the assembler and pick the next phase
            if (do_next) begin
                n_word = '0;
                n_abc  = '0;
                if (n_cursor >= r_count) n_phase = PH_DONE;
                else                     n_phase = next_al ? PH_ARG : PH_ARG_PAD;
            end

            if (i_eop) begin
                ent.has_verdict = 1'b1;
                ent.ok          = !n_failed && (n_phase == PH_DONE) && (r_pos >= MIN_LAST_POS);
                n_phase  = PH_ADDR_START;
                n_pos    = '0;
                n_count  = '0;
                n_cursor = '0;
                n_word   = '0;
                n_abc    = '0;
                n_iused  = '0;
                n_fused  = '0;
                n_tused  = '0;
                n_sused  = '0;
                n_failed = 1'b0;
            end else begin
                n_pos = (r_pos >= POS_MAX) ? POS_WRAP : r_pos + 16'd1;
            end
        end
    end

    assign o_push  = accept && (ent.has_data || ent.has_verdict);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ADDR_START;
            r_pos    <= '0;
            r_count  <= '0;
            r_cursor <= '0;
            r_word   <= '0;
            r_abc    <= '0;
            r_iused  <= '0;
            r_fused  <= '0;
            r_tused  <= '0;
            r_sused  <= '0;
            r_failed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_word   <= n_word;
            r_abc    <= n_abc;
            r_iused  <= n_iused;
            r_fused  <= n_fused;
            r_tused  <= n_tused;
            r_sused  <= n_sused;
            r_failed <= n_failed;
        end
    end

    // tag store: written at the fill count, read ahead at the next cursor so r_tag matches the cursor
    always_ff @(posedge i_clk) begin
        if (tag_we) r_tag_mem[r_count[TW-1:0]] <= i_byte;
        r_tag <= r_tag_mem[n_cursor[TW-1:0]];
    end

endmodule

// ===== hdl/omp_queue.sv =====
// ============================================================================
// omp_queue - short entry queue between front and back
// Holds per-byte result entries so that each side may stall on its own.
// ============================================================================
module omp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  omp_pkg::t_entry i_entry,
    output logic            o_room,
    input  logic            i_pop,
    output logic            o_avail,
    output omp_pkg::t_entry o_head
);
    import omp_pkg::*;

    t_entry           r_slots [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_fill;

    assign o_room  = (r_fill != (QAW+1)'(QDEPTH));
    assign o_avail = (r_fill != '0);
    assign o_head  = r_slots[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wr] <= i_entry;
    end

endmodule

// ===== hdl/omp_back.sv =====
// ============================================================================
// omp_back - result serialiser and output register
// Splits each queue entry into its data result and verdict, one word a cycle unless stalled.
// ============================================================================
module omp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  omp_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [3:0]      o_kind,
    output logic [2:0]      o_slot,
    output logic [63:0]     o_value,
    output logic            o_last
);
    import omp_pkg::*;

    logic        r_valid;
    logic        r_data_sent;
    logic [3:0]  r_kind;
    logic [2:0]  r_slot;
    logic [63:0] r_value;
    logic        r_last;

    logic        load;
    logic        take_data;

    assign load      = i_avail && (!r_valid || i_ready);
    assign take_data = i_head.has_data && !r_data_sent;
    assign o_pop     = load && !(take_data && i_head.has_verdict);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_data_sent <= 1'b0;
        end else begin
            if (load) begin
                r_valid     <= 1'b1;
                r_data_sent <= take_data && i_head.has_verdict;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (take_data) begin
                r_kind  <= i_head.kind;
                r_slot  <= i_head.slot;
                r_value <= i_head.value;
                r_last  <= !i_head.has_verdict;
            end else begin
                r_kind  <= i_head.ok ? KIND_ACCEPTED : KIND_REJECTED;
                r_slot  <= '0;
                r_value <= '0;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_slot  = r_slot;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

// ===== hdl/osc_message_parser.sv =====
// ============================================================================
// osc_message_parser - streaming OSC 1.1 message parser
// Parses one packet byte per word and streams out decoded fields and a verdict.
// ============================================================================
// Usage
//   Slave side: one packet byte per word in i_s_tdata, i_s_tlast on the final
//   byte. Master side: one result per word; o_m_tuser is the kind, o_m_tdata
//   holds slot and value, o_m_tlast marks the final result of an input byte.
//   A byte gives at most two results: a data result (address byte, tag, int,
//   float bits, timetag, string byte or string end) and, on the last byte of a
//   packet, accepted or rejected.
// Timing
//   A byte is taken every cycle while the four-entry queue has room. A result
//   passes from the parser into a queue slot and from there into the output
//   register. The output drains one word a cycle while i_m_tready allows, so a
//   byte with two results leaves the back end as two words.
// Stalls and reset
//   When i_m_tready is low the output holds; the queue fills and then
//   o_s_tready drops until space frees up. Reset clears the parser, the queue
//   and the output valid flag; the tag store needs no clearing.
// ============================================================================
module osc_message_parser #(
    parameter int MAX_SLOTS = 8,   // emitted arguments per kind, 1..8
    parameter int TAG_DEPTH = 16   // type tags held per packet, 1..256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_packet
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [2:0] slot, [66:3] value, [71:67] zero
    output logic [3:0]  o_m_tuser,   // [3:0] kind
    output logic        o_m_tlast    // last
);
    import omp_pkg::*;

    t_entry      front_entry;
    t_entry      head_entry;
    logic        front_push;
    logic        q_room;
    logic        q_avail;
    logic        back_pop;
    logic [2:0]  out_slot;
    logic [63:0] out_value;

    // front: phase walk, tag store and field assembly
    omp_front #(
        .MAX_SLOTS (MAX_SLOTS),
        .TAG_DEPTH (TAG_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_eop   (i_s_tlast),
        .i_room  (q_room),
        .o_ready (o_s_tready),
        .o_push  (front_push),
        .o_entry (front_entry)
    );

    // decoupling queue, one entry per byte that has results
    omp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_room  (q_room),
        .i_pop   (back_pop),
        .o_avail (q_avail),
        .o_head  (head_entry)
    );

    // back: serialise data result and verdict into the output register
    omp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_head  (head_entry),
        .o_pop   (back_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_slot  (out_slot),
        .o_value (out_value),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {5'd0, out_value, out_slot};

endmodule
